[hdl/cpr_pkg.sv]
// shared constants and types for the clock page replacement unit
`default_nettype none

package cpr_pkg;

    localparam int MAX_FRAMES_DEF = 64;
    localparam int FRAME_W        = 6;
    localparam int FRAME_SPACE    = 64;
    localparam int CAP_W          = 7;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    localparam logic KIND_REF   = 1'b0;
    localparam logic KIND_EVICT = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

endpackage

`default_nettype wire

[hdl/clock_page_replacement_unit.sv]
// second-chance (clock) page replacement unit, top level
//
// channel  | dir | handshake           | payload
// ---------+-----+---------------------+-------------------------------------------
// s_       | in  | s_tvalid / s_tready | tuser: kind; tdata: frame_number
// m_       | out | m_tvalid / m_tready | tdata: evicted_frame; tuser: valid, status
// cfg_     | in  | cfg_wr_en           | cfg_wr_data: capacity
//
// one beat in gives one beat out; a single frame list ram port pair is walked one
// entry per cycle. a reference searches the entries and appends on a miss; an evict
// scans for the victim, then closes up the entries behind it; an empty evict ends at once.
// reset clears the count and the reference bits at once, no clearing pass.
// s_tready is high only while idle; a result held by m_tready stalls the sequencer.
`default_nettype none

module clock_page_replacement_unit #(
    parameter int MAX_FRAMES = cpr_pkg::MAX_FRAMES_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [7:0]                s_tdata,     // [5:0] frame_number
    input  wire logic                      s_tuser,     // [0] kind
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic      [7:0]                m_tdata,     // [5:0] evicted_frame
    output logic      [2:0]                m_tuser,     // [0] evict_valid, [2:1] status
    input  wire logic                      cfg_wr_en,
    input  wire logic [cpr_pkg::CAP_W-1:0] cfg_wr_data
);

    localparam int AW   = $clog2(MAX_FRAMES);
    localparam int CNTW = $clog2(MAX_FRAMES + 1);
    localparam int LW   = (CNTW > cpr_pkg::CAP_W) ? CNTW : cpr_pkg::CAP_W;
    localparam int FW   = cpr_pkg::FRAME_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_SCAN,
        ST_SHIFT,
        ST_RESULT
    } state_t;

    state_t                       state_reg, state_next;
    logic [CNTW-1:0]              count_reg, count_next;
    logic [cpr_pkg::CAP_W-1:0]    cap_reg, cap_next;
    logic [cpr_pkg::FRAME_SPACE-1:0] ref_reg, ref_next;
    logic [AW-1:0]                idx_reg, idx_next;
    logic [FW-1:0]                frame_reg, frame_next;
    logic [FW-1:0]                res_frame_reg, res_frame_next;
    logic                         res_valid_reg, res_valid_next;
    cpr_pkg::status_t             res_status_reg, res_status_next;
    logic                         m_tvalid_reg, m_tvalid_next;
    logic [FW-1:0]                m_frame_reg, m_frame_next;
    logic                         m_valid_reg, m_valid_next;
    cpr_pkg::status_t             m_status_reg, m_status_next;

    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [FW-1:0]                ram_wdata;
    logic [AW-1:0]                ram_raddr;
    logic [FW-1:0]                ram_rdata;

    logic [LW-1:0]                limit;
    logic                         list_full;
    logic [FW-1:0]                app_frame;
    logic [CNTW-1:0]              idx_p1;
    logic [CNTW-1:0]              idx_p2;
    logic [AW-1:0]                idx_wrap;

    cpr_ram #(
        .WIDTH (FW),
        .DEPTH (MAX_FRAMES)
    ) u_frame_list (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // capacity above the list depth acts as the depth
    assign limit = (LW'(cap_reg) > LW'(MAX_FRAMES)) ? LW'(MAX_FRAMES) : LW'(cap_reg);
    assign list_full = (LW'(count_reg) >= limit);
    assign app_frame = (state_reg == ST_IDLE) ? s_tdata[FW-1:0] : frame_reg;

    assign idx_p1   = CNTW'(idx_reg) + CNTW'(1);
    assign idx_p2   = CNTW'(idx_reg) + CNTW'(2);
    assign idx_wrap = (idx_p1 == count_reg) ? '0 : idx_p1[AW-1:0];

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(8 - FW){1'b0}}, m_frame_reg};
    assign m_tuser  = {m_status_reg, m_valid_reg};

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        cap_next        = cfg_wr_en ? cfg_wr_data : cap_reg;
        ref_next        = ref_reg;
        idx_next        = idx_reg;
        frame_next      = frame_reg;
        res_frame_next  = res_frame_reg;
        res_valid_next  = res_valid_reg;
        res_status_next = res_status_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_frame_next    = m_frame_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        ram_we          = 1'b0;
        ram_waddr       = count_reg[AW-1:0];
        ram_wdata       = app_frame;
        ram_raddr       = '0;

        unique case (state_reg)
            ST_IDLE: begin
                // entry 0 is read here so it is ready in the first look or scan cycle
                ram_raddr = '0;
                if (s_tvalid) begin
                    frame_next     = s_tdata[FW-1:0];
                    idx_next       = '0;
                    res_frame_next = '0;
                    res_valid_next = 1'b0;
                    res_status_next = cpr_pkg::STATUS_OK;
                    if (s_tuser == cpr_pkg::KIND_EVICT) begin
                        if (count_reg == '0) begin
                            res_status_next = cpr_pkg::STATUS_EMPTY;
                            state_next      = ST_RESULT;
                        end else begin
                            state_next = ST_SCAN;
                        end
                    end else if (count_reg == '0) begin
                        // nothing to search: append straight away, or report full if there is no room
                        if (list_full) begin
                            res_status_next = cpr_pkg::STATUS_FULL;
                        end else begin
                            ram_we               = 1'b1;
                            ref_next[app_frame]  = 1'b1;
                            count_next           = count_reg + CNTW'(1);
                        end
                        state_next = ST_RESULT;
                    end else begin
                        state_next = ST_LOOK;
                    end
                end
            end

            ST_LOOK: begin
                ram_raddr = idx_p1[AW-1:0];
                if (ram_rdata == frame_reg) begin
                    ref_next[frame_reg] = 1'b1;
                    state_next          = ST_RESULT;
                end else if (idx_p1 == count_reg) begin
                    if (list_full) begin
                        res_status_next = cpr_pkg::STATUS_FULL;
                    end else begin
                        ram_we              = 1'b1;
                        ref_next[app_frame] = 1'b1;
                        count_next          = count_reg + CNTW'(1);
                    end
                    state_next = ST_RESULT;
                end else begin
                    idx_next = idx_p1[AW-1:0];
                end
            end

            ST_SCAN: begin
                ram_raddr = idx_wrap;
                if (!ref_reg[ram_rdata]) begin
                    res_frame_next = ram_rdata;
                    res_valid_next = 1'b1;
                    if (idx_p1 == count_reg) begin
                        // victim at the tail, nothing to close up
                        count_next = count_reg - CNTW'(1);
                        state_next = ST_RESULT;
                    end else begin
                        state_next = ST_SHIFT;
                    end
                end else begin
                    ref_next[ram_rdata] = 1'b0;
                    idx_next            = idx_wrap;
                end
            end

            ST_SHIFT: begin
                // rdata holds entry idx+1, moved down to idx
                ram_raddr = idx_p2[AW-1:0];
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = ram_rdata;
                if (idx_p2 == count_reg) begin
                    count_next = count_reg - CNTW'(1);
                    state_next = ST_RESULT;
                end else begin
                    idx_next = idx_p1[AW-1:0];
                end
            end

            ST_RESULT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_frame_next  = res_frame_reg;
                    m_valid_next  = res_valid_reg;
                    m_status_next = res_status_reg;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            cap_reg        <= cpr_pkg::CAP_RESET;
            ref_reg        <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            cap_reg        <= cap_next;
            ref_reg        <= ref_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
        idx_reg        <= idx_next;
        frame_reg      <= frame_next;
        res_frame_reg  <= res_frame_next;
        res_valid_reg  <= res_valid_next;
        res_status_reg <= res_status_next;
        m_frame_reg    <= m_frame_next;
        m_valid_reg    <= m_valid_next;
        m_status_reg   <= m_status_next;
    end

endmodule

`default_nettype wire

[hdl/cpr_ram.sv]
// generic single write port ram with registered read
`default_nettype none

module cpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

[dv/tb_clock_page_replacement_unit.sv]
// testbench for the clock page replacement unit: directed table, then random phases
`default_nettype none

module tb_clock_page_replacement_unit;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [cpr_pkg::FRAME_W-1:0] frame;
        logic                        valid;
        cpr_pkg::status_t            status;
    } evict_result_t;

    typedef struct {
        bit                          set_cap;
        logic [cpr_pkg::CAP_W-1:0]   cap;
        logic                        kind;
        logic [cpr_pkg::FRAME_W-1:0] frame;
        bit                          typed;
        evict_result_t               result;
    } access_row_t;

    logic                        aclk        = 1'b0;
    logic                        aresetn     = 1'b0;
    logic                        s_tvalid    = 1'b0;
    logic                        s_tready;
    logic [7:0]                  s_tdata     = '0;   // [5:0] frame_number
    logic                        s_tuser     = 1'b0; // [0] kind
    logic                        m_tvalid;
    logic                        m_tready    = 1'b0;
    logic [7:0]                  m_tdata;            // [5:0] evicted_frame
    logic [2:0]                  m_tuser;            // [0] evict_valid, [2:1] status
    logic                        cfg_wr_en   = 1'b0;
    logic [cpr_pkg::CAP_W-1:0]   cfg_wr_data = '0;

    // shadow of the replacement state
    logic [cpr_pkg::FRAME_W-1:0] resident_frames [cpr_pkg::MAX_FRAMES_DEF];
    logic                        referenced [cpr_pkg::FRAME_SPACE];
    int unsigned                 resident_count;
    int unsigned                 capacity_reg;

    evict_result_t               expected_results [$];
    access_row_t                 access_table [$];
    int                          mismatch_count = 0;
    bit                          calm = 1'b0;

    clock_page_replacement_unit u_top (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic evict_result_t predict_access(input logic kind,
                                                     input logic [cpr_pkg::FRAME_W-1:0] frame);
        evict_result_t res;
        int unsigned   limit;
        int unsigned   pos;
        int unsigned   guard;
        logic [cpr_pkg::FRAME_W-1:0] f;
        bit            hit;
        bit            found;
        res.frame  = '0;
        res.valid  = 1'b0;
        res.status = cpr_pkg::STATUS_OK;
        limit = (capacity_reg > cpr_pkg::MAX_FRAMES_DEF) ? cpr_pkg::MAX_FRAMES_DEF
                                                          : capacity_reg;
        if (kind == cpr_pkg::KIND_REF) begin
            hit = 1'b0;
            for (int i = 0; i < resident_count; i++)
                if (resident_frames[i] == frame)
                    hit = 1'b1;
            if (hit) begin
                referenced[frame] = 1'b1;
            end else if (resident_count >= limit) begin
                res.status = cpr_pkg::STATUS_FULL;
            end else begin
                resident_frames[resident_count] = frame;
                referenced[frame] = 1'b1;
                resident_count++;
            end
        end else if (resident_count == 0) begin
            res.status = cpr_pkg::STATUS_EMPTY;
        end else begin
            // second chance sweep, clears bits until an unreferenced entry turns up
            pos   = 0;
            guard = 0;
            found = 1'b0;
            while (!found && guard < 2 * resident_count + 1) begin
                f = resident_frames[pos];
                if (!referenced[f]) begin
                    found = 1'b1;
                end else begin
                    referenced[f] = 1'b0;
                    pos = (pos + 1 == resident_count) ? 0 : pos + 1;
                    guard++;
                end
            end
            res.frame = resident_frames[pos];
            res.valid = 1'b1;
            for (int i = pos; i + 1 < resident_count; i++)
                resident_frames[i] = resident_frames[i + 1];
            resident_count--;
        end
        return res;
    endfunction

    // offer one beat and record what it should produce once it is taken
    task automatic issue_access(input logic kind, input logic [cpr_pkg::FRAME_W-1:0] frame,
                                input bit typed, input evict_result_t typed_result);
        int unsigned   gap;
        evict_result_t res;
        if (!calm && $urandom_range(99) < 23) begin
            s_tvalid <= 1'b0;
            gap = ($urandom_range(19) == 0) ? $urandom_range(150, 1) : $urandom_range(4, 1);
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {2'b00, frame};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        res = predict_access(kind, frame);
        expected_results.push_back(typed ? typed_result : res);
    endtask

    task automatic wait_until_drained();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [cpr_pkg::CAP_W-1:0] value);
        wait_until_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        capacity_reg = value;
    endtask

    task automatic add_row(input bit set_cap, input logic [cpr_pkg::CAP_W-1:0] cap,
                           input logic kind, input logic [cpr_pkg::FRAME_W-1:0] frame,
                           input bit typed, input logic [cpr_pkg::FRAME_W-1:0] exp_frame,
                           input logic exp_valid, input cpr_pkg::status_t exp_status);
        access_row_t r;
        r.set_cap       = set_cap;
        r.cap           = cap;
        r.kind          = kind;
        r.frame         = frame;
        r.typed         = typed;
        r.result.frame  = exp_frame;
        r.result.valid  = exp_valid;
        r.result.status = exp_status;
        access_table.push_back(r);
    endtask

    // result side: random backpressure and in-order compare
    always @(posedge aclk) begin
        evict_result_t want;
        m_tready <= calm || ($urandom_range(99) >= 23);
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result beat, actual tdata %0h tuser %0h",
                         $time, m_tdata, m_tuser);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                if (m_tdata[cpr_pkg::FRAME_W-1:0] !== want.frame) begin
                    $display("%0t: evicted_frame expected %0d actual %0d",
                             $time, want.frame, m_tdata[cpr_pkg::FRAME_W-1:0]);
                    mismatch_count++;
                end
                if (m_tuser[0] !== want.valid) begin
                    $display("%0t: evict_valid expected %0d actual %0d",
                             $time, want.valid, m_tuser[0]);
                    mismatch_count++;
                end
                if (m_tuser[2:1] !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, m_tuser[2:1]);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        access_row_t               r;
        evict_result_t             none;
        logic [cpr_pkg::CAP_W-1:0] phase_cap [13];
        int unsigned               evict_pct [13];
        int unsigned               pool_hi [13];
        phase_cap = '{7'd64, 7'd127, 7'd5, 7'd0, 7'd1, 7'd2, 7'd16, 7'd8,
                      7'd63, 7'd3, 7'd33, 7'd100, 7'd64};
        evict_pct = '{4, 3, 30, 45, 25, 20, 35, 50, 10, 40, 30, 25, 15};
        pool_hi   = '{63, 63, 7, 3, 15, 63, 31, 7, 63, 3, 15, 63, 63};
        none = '0;

        for (int i = 0; i < cpr_pkg::FRAME_SPACE; i++)
            referenced[i] = 1'b0;
        for (int i = 0; i < cpr_pkg::MAX_FRAMES_DEF; i++)
            resident_frames[i] = '0;
        resident_count = 0;
        capacity_reg   = cpr_pkg::CAP_RESET;

        //      cap? cap     kind                 frame  typed  frame valid status
        add_row(0, 7'd0,   cpr_pkg::KIND_EVICT, 6'd0,  1,     6'd0, 0, cpr_pkg::STATUS_EMPTY);
        add_row(0, 7'd0,   cpr_pkg::KIND_EVICT, 6'd63, 1,     6'd0, 0, cpr_pkg::STATUS_EMPTY);
        add_row(0, 7'd0,   cpr_pkg::KIND_REF,   6'd0,  1,     6'd0, 0, cpr_pkg::STATUS_OK);
        add_row(0, 7'd0,   cpr_pkg::KIND_REF,   6'd63, 1,     6'd0, 0, cpr_pkg::STATUS_OK);
        add_row(0, 7'd0,   cpr_pkg::KIND_REF,   6'd0,  1,     6'd0, 0, cpr_pkg::STATUS_OK);
        add_row(0, 7'd0,   cpr_pkg::KIND_REF,   6'd42, 1,     6'd0, 0, cpr_pkg::STATUS_OK);
        add_row(0, 7'd0,   cpr_pkg::KIND_EVICT, 6'd21, 0,     6'd0, 0, cpr_pkg::STATUS_OK);
        add_row(0, 7'd0,   cpr_pkg::KIND_EVICT, 6'd0,  0,     6'd0, 0, cpr_pkg::STATUS_OK);
        add_row(1, 7'd1,   cpr_pkg::KIND_REF,   6'd5,  1,     6'd0, 0, cpr_pkg::STATUS_FULL);
        add_row(0, 7'd0,   cpr_pkg::KIND_REF,   6'd42, 1,     6'd0, 0, cpr_pkg::STATUS_OK);
        add_row(1, 7'd0,   cpr_pkg::KIND_REF,   6'd9,  1,     6'd0, 0, cpr_pkg::STATUS_FULL);
        add_row(0, 7'd0,   cpr_pkg::KIND_REF,   6'd42, 1,     6'd0, 0, cpr_pkg::STATUS_OK);
        add_row(0, 7'd0,   cpr_pkg::KIND_EVICT, 6'd42, 0,     6'd0, 0, cpr_pkg::STATUS_OK);
        add_row(0, 7'd0,   cpr_pkg::KIND_REF,   6'd9,  1,     6'd0, 0, cpr_pkg::STATUS_FULL);
        add_row(0, 7'd0,   cpr_pkg::KIND_EVICT, 6'd63, 1,     6'd0, 0, cpr_pkg::STATUS_EMPTY);
        add_row(1, 7'd127, cpr_pkg::KIND_REF,   6'd1,  1,     6'd0, 0, cpr_pkg::STATUS_OK);
        add_row(0, 7'd0,   cpr_pkg::KIND_REF,   6'd2,  1,     6'd0, 0, cpr_pkg::STATUS_OK);
        add_row(0, 7'd0,   cpr_pkg::KIND_REF,   6'd3,  1,     6'd0, 0, cpr_pkg::STATUS_OK);
        add_row(0, 7'd0,   cpr_pkg::KIND_EVICT, 6'd0,  0,     6'd0, 0, cpr_pkg::STATUS_OK);
        add_row(0, 7'd0,   cpr_pkg::KIND_REF,   6'd3,  0,     6'd0, 0, cpr_pkg::STATUS_OK);
        add_row(0, 7'd0,   cpr_pkg::KIND_EVICT, 6'd0,  0,     6'd0, 0, cpr_pkg::STATUS_OK);
        add_row(1, 7'd2,   cpr_pkg::KIND_REF,   6'd4,  0,     6'd0, 0, cpr_pkg::STATUS_OK);
        add_row(0, 7'd0,   cpr_pkg::KIND_REF,   6'd5,  0,     6'd0, 0, cpr_pkg::STATUS_OK);
        add_row(0, 7'd0,   cpr_pkg::KIND_REF,   6'd62, 0,     6'd0, 0, cpr_pkg::STATUS_OK);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (access_table[i]) begin
            r = access_table[i];
            if (r.set_cap)
                write_capacity(r.cap);
            issue_access(r.kind, r.frame, r.typed, r.result);
        end

        // random phases, each under its own capacity; one phase runs without idling
        for (int p = 0; p < 13; p++) begin
            write_capacity(p == 11 ? cpr_pkg::CAP_W'($urandom_range(127)) : phase_cap[p]);
            calm = (p == 5);
            for (int n = 0; n < 100; n++) begin
                if ($urandom_range(99) < evict_pct[p])
                    issue_access(cpr_pkg::KIND_EVICT,
                                 cpr_pkg::FRAME_W'($urandom_range(63)), 1'b0, none);
                else
                    issue_access(cpr_pkg::KIND_REF,
                                 cpr_pkg::FRAME_W'($urandom_range(pool_hi[p])), 1'b0, none);
            end
        end
        calm = 1'b0;

        wait_until_drained();
        repeat (150) @(posedge aclk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire

[clock_page_replacement_unit.f]
hdl/cpr_pkg.sv
hdl/cpr_ram.sv
hdl/clock_page_replacement_unit.sv
dv/tb_clock_page_replacement_unit.sv
